// ===== src/fbba_pkg.sv =====
package fbba_pkg;

    // Map geometry
    localparam int BLOCK_COUNT     = 65536;
    localparam int RESERVED_BLOCKS = 8;
    localparam int MAX_REQUEST     = 16;

    localparam int WORD_W    = 64;
    localparam int OFF_W     = 6;
    localparam int MAP_WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LAST_WORD = MAP_WORDS - 1;
    localparam int TAIL_BITS = BLOCK_COUNT - LAST_WORD * WORD_W;
    localparam int RES_EFF   = (RESERVED_BLOCKS > BLOCK_COUNT) ? BLOCK_COUNT : RESERVED_BLOCKS;
    localparam int REM_W     = $clog2(MAX_REQUEST + 1);

    // Field widths
    localparam int OP_W     = 2;
    localparam int BLK_W    = 16;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 2;
    localparam int HINT_W   = 17;

    // Valid bits of the last map word
    localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL_BITS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

endpackage

// ===== src/free_block_bitmap_allocator.sv =====
// Free block bitmap allocator.
// Requests enter on req_valid/req_stall with op, block_index and count;
// results leave on res_valid/res_stall, one field per port, last marking
// the final result of each request.
// Mark used and mark free take one read-modify-write of the 64-bit map
// word, query one read: the result is registered in S_RMW once the output
// register is free, and no new request is taken until it is loaded.
// Find scans map words upward from the first-free hint, reading and masking
// each word (S_FLOAD) and reporting its free blocks one per cycle (S_FEMIT)
// unless res_stall holds; the single-port-read map memory sets this pace.
// After reset the map memory is initialized one word per cycle, all
// (BLOCK_COUNT+63)/64 words (1024 at the default size), with the reserved
// blocks marked used; no request is taken until that pass ends.
// The result sits in an output register; while res_stall is high the
// result holds and the block waits, and a new request may be taken while
// a finished result is still waiting.
module free_block_bitmap_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [fbba_pkg::OP_W-1:0]       op,
    input  logic [fbba_pkg::BLK_W-1:0]      block_index,
    input  logic [fbba_pkg::CNT_W-1:0]      count,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [fbba_pkg::STATUS_W-1:0]   status,
    output logic [fbba_pkg::BLK_W-1:0]      block_index_out,
    output logic                            block_valid,
    output logic                            used,
    output logic                            last
);

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SINGLE,
        S_FLOAD,
        S_FEMIT
    } state_t;

    localparam logic [fbba_pkg::WADDR_W-1:0] LAST_ADDR =
        fbba_pkg::WADDR_W'(fbba_pkg::LAST_WORD);
    localparam logic [fbba_pkg::HINT_W-1:0] BLOCK_END =
        fbba_pkg::HINT_W'(fbba_pkg::BLOCK_COUNT);
    localparam logic [fbba_pkg::WORD_W-1:0] ALL_ONES = {fbba_pkg::WORD_W{1'b1}};

    // Reset image of one map word
    function automatic logic [fbba_pkg::WORD_W-1:0] reserved_mask
    (
        input logic [fbba_pkg::WADDR_W-1:0] w
    );
        int lo;
        logic [fbba_pkg::WORD_W-1:0] m;
        lo = int'(w) * fbba_pkg::WORD_W;
        if (fbba_pkg::RES_EFF >= lo + fbba_pkg::WORD_W)
            m = ALL_ONES;
        else if (fbba_pkg::RES_EFF <= lo)
            m = '0;
        else
            m = ALL_ONES >> (fbba_pkg::WORD_W - (fbba_pkg::RES_EFF - lo));
        return m;
    endfunction

    // Word address of a block number
    function automatic logic [fbba_pkg::WADDR_W-1:0] word_of
    (
        input logic [fbba_pkg::HINT_W-1:0] b
    );
        return fbba_pkg::WADDR_W'(b >> fbba_pkg::OFF_W);
    endfunction

    state_t                              state_reg;
    logic [fbba_pkg::WADDR_W-1:0]        clr_addr_reg;
    logic [fbba_pkg::OP_W-1:0]           op_reg;
    logic [fbba_pkg::BLK_W-1:0]          idx_reg;
    logic [fbba_pkg::REM_W-1:0]          rem_reg;
    logic [fbba_pkg::HINT_W-1:0]         hint_reg;
    logic [fbba_pkg::WADDR_W-1:0]        scan_word_reg;
    logic                                first_reg;
    logic [fbba_pkg::WORD_W-1:0]         fvec_reg;
    logic [fbba_pkg::STATUS_W-1:0]       single_status_reg;

    logic                                res_valid_reg;
    logic [fbba_pkg::STATUS_W-1:0]       status_reg;
    logic [fbba_pkg::BLK_W-1:0]          block_index_out_reg;
    logic                                block_valid_reg;
    logic                                used_reg;
    logic                                last_reg;

    // Map memory
    logic [fbba_pkg::WORD_W-1:0]         map_mem [fbba_pkg::MAP_WORDS];
    logic [fbba_pkg::WORD_W-1:0]         rdata_reg;
    logic                                mem_re;
    logic [fbba_pkg::WADDR_W-1:0]        raddr;
    logic                                mem_we;
    logic [fbba_pkg::WADDR_W-1:0]        waddr;
    logic [fbba_pkg::WORD_W-1:0]         wdata;

    logic                                req_take;
    logic                                out_free;
    logic                                res_load;
    logic [fbba_pkg::HINT_W-1:0]         idx_ext;
    logic [fbba_pkg::HINT_W-1:0]         in_ext;
    logic                                in_range;
    logic [fbba_pkg::REM_W-1:0]          cnt_sat;
    logic [fbba_pkg::WORD_W-1:0]         bit_sel;
    logic [fbba_pkg::WORD_W-1:0]         fvec_load;
    logic [fbba_pkg::WORD_W-1:0]         low_one;
    logic [fbba_pkg::OFF_W-1:0]          low_pos;
    logic [fbba_pkg::HINT_W-1:0]         found_blk;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    // Load a new result into the output register this cycle
    assign res_load  = out_free && ((state_reg == S_RMW) || (state_reg == S_SINGLE)
                     || ((state_reg == S_FEMIT) && (fvec_reg != '0)));

    assign idx_ext  = fbba_pkg::HINT_W'(idx_reg);
    assign in_ext   = fbba_pkg::HINT_W'(block_index);
    assign in_range = (in_ext < BLOCK_END);
    assign cnt_sat  = (int'(count) > fbba_pkg::MAX_REQUEST) ?
                      fbba_pkg::REM_W'(fbba_pkg::MAX_REQUEST) : fbba_pkg::REM_W'(count);
    assign bit_sel  = fbba_pkg::WORD_W'(1) << idx_reg[fbba_pkg::OFF_W-1:0];

    // Mask the loaded word down to free blocks at or above the hint
    assign fvec_load = ~rdata_reg
                     & (first_reg ? (ALL_ONES << hint_reg[fbba_pkg::OFF_W-1:0]) : ALL_ONES)
                     & ((scan_word_reg == LAST_ADDR) ? fbba_pkg::TAIL_MASK : ALL_ONES);

    // Isolate and encode the lowest free block of the word
    assign low_one = fvec_reg & (~fvec_reg + fbba_pkg::WORD_W'(1));

    always_comb
    begin
        low_pos = '0;
        for (int b = 0; b < fbba_pkg::WORD_W; b++)
        begin
            if (low_one[b])
                low_pos = low_pos | fbba_pkg::OFF_W'(b);
        end
    end

    assign found_blk = (fbba_pkg::HINT_W'(scan_word_reg) << fbba_pkg::OFF_W)
                     | fbba_pkg::HINT_W'(low_pos);

    // Select memory read and write ports
    always_comb
    begin
        mem_re = 1'b0;
        raddr  = scan_word_reg + fbba_pkg::WADDR_W'(1);
        mem_we = 1'b0;
        waddr  = word_of(idx_ext);
        wdata  = rdata_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                waddr  = clr_addr_reg;
                wdata  = reserved_mask(clr_addr_reg);
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (op == fbba_pkg::OP_FIND)
                    begin
                        mem_re = 1'b1;
                        raddr  = word_of(hint_reg);
                    end
                    else
                    begin
                        mem_re = in_range;
                        raddr  = word_of(in_ext);
                    end
                end
            end
            S_RMW:
            begin
                if (out_free && op_reg != fbba_pkg::OP_QUERY)
                begin
                    mem_we = 1'b1;
                    if (op_reg == fbba_pkg::OP_MARK_USED)
                        wdata = rdata_reg | bit_sel;
                    else
                        wdata = rdata_reg & ~bit_sel;
                end
            end
            S_FEMIT:
            begin
                mem_re = (fvec_reg == '0) && (scan_word_reg != LAST_ADDR);
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Hold the map and register read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= map_mem[raddr];
    end

    // Advance the request sequencer and load results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            hint_reg      <= fbba_pkg::HINT_W'(fbba_pkg::RES_EFF);
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Fill or drain the output register
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + fbba_pkg::WADDR_W'(1);
                    if (clr_addr_reg == LAST_ADDR)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        op_reg  <= op;
                        idx_reg <= block_index;
                        if (op != fbba_pkg::OP_FIND)
                        begin
                            if (in_range)
                                state_reg <= S_RMW;
                            else
                            begin
                                single_status_reg <= fbba_pkg::ST_RANGE;
                                state_reg         <= S_SINGLE;
                            end
                        end
                        else if (cnt_sat == '0)
                        begin
                            single_status_reg <= fbba_pkg::ST_OK;
                            state_reg         <= S_SINGLE;
                        end
                        else if (hint_reg >= BLOCK_END)
                        begin
                            single_status_reg <= fbba_pkg::ST_NOSPACE;
                            state_reg         <= S_SINGLE;
                        end
                        else
                        begin
                            rem_reg       <= cnt_sat;
                            scan_word_reg <= word_of(hint_reg);
                            first_reg     <= 1'b1;
                            state_reg     <= S_FLOAD;
                        end
                    end
                end
                S_RMW:
                begin
                    if (out_free)
                    begin
                        status_reg          <= fbba_pkg::ST_OK;
                        last_reg            <= 1'b1;
                        block_valid_reg     <= (op_reg == fbba_pkg::OP_QUERY);
                        block_index_out_reg <= (op_reg == fbba_pkg::OP_QUERY) ? idx_reg : '0;
                        used_reg            <= (op_reg == fbba_pkg::OP_QUERY)
                                               && |(rdata_reg & bit_sel);
                        if (op_reg == fbba_pkg::OP_MARK_USED)
                        begin
                            if (idx_ext == hint_reg)
                                hint_reg <= hint_reg + fbba_pkg::HINT_W'(1);
                        end
                        else if (op_reg == fbba_pkg::OP_MARK_FREE && idx_ext < hint_reg)
                            hint_reg <= idx_ext;
                        state_reg <= S_IDLE;
                    end
                end
                S_SINGLE:
                begin
                    if (out_free)
                    begin
                        status_reg          <= single_status_reg;
                        last_reg            <= 1'b1;
                        block_valid_reg     <= 1'b0;
                        block_index_out_reg <= '0;
                        used_reg            <= 1'b0;
                        state_reg           <= S_IDLE;
                    end
                end
                S_FLOAD:
                begin
                    fvec_reg  <= fvec_load;
                    first_reg <= 1'b0;
                    state_reg <= S_FEMIT;
                end
                S_FEMIT:
                begin
                    if (fvec_reg == '0)
                    begin
                        if (scan_word_reg == LAST_ADDR)
                        begin
                            single_status_reg <= fbba_pkg::ST_NOSPACE;
                            state_reg         <= S_SINGLE;
                        end
                        else
                        begin
                            scan_word_reg <= scan_word_reg + fbba_pkg::WADDR_W'(1);
                            state_reg     <= S_FLOAD;
                        end
                    end
                    else if (out_free)
                    begin
                        status_reg          <= fbba_pkg::ST_OK;
                        block_valid_reg     <= 1'b1;
                        block_index_out_reg <= fbba_pkg::BLK_W'(found_blk);
                        used_reg            <= 1'b0;
                        last_reg            <= (rem_reg == fbba_pkg::REM_W'(1));
                        rem_reg             <= rem_reg - fbba_pkg::REM_W'(1);
                        fvec_reg            <= fvec_reg & (fvec_reg - fbba_pkg::WORD_W'(1));
                        if (rem_reg == fbba_pkg::REM_W'(1))
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid       = res_valid_reg;
    assign status          = status_reg;
    assign block_index_out = block_index_out_reg;
    assign block_valid     = block_valid_reg;
    assign used            = used_reg;
    assign last            = last_reg;

`ifndef SYNTH
    a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLOAD || state_reg == S_FEMIT) |-> !mem_we)
        else $error("map written during find scan");

    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= BLOCK_END)
        else $error("first-free hint beyond map end");

    a_find_wants: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEMIT) |-> (rem_reg != '0))
        else $error("find scan running with nothing wanted");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (req_stall && !res_valid_reg))
        else $error("request or result during map clear");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_stall && last_reg && state_reg == S_IDLE)
        |=> !res_valid_reg || $past(req_take))
        else $error("result after last without new request");
`endif

endmodule

// ===== tb/tb_free_block_bitmap_allocator.sv =====
`timescale 1ns / 100ps

module tb_free_block_bitmap_allocator;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_CYCLES   = 24;

    typedef struct packed {
        logic [fbba_pkg::OP_W-1:0]  op;
        logic [fbba_pkg::BLK_W-1:0] idx;
        logic [fbba_pkg::CNT_W-1:0] cnt;
    } request_t;

    typedef struct packed {
        logic [fbba_pkg::STATUS_W-1:0] status;
        logic [fbba_pkg::BLK_W-1:0]    blk;
        logic                          bvalid;
        logic                          used;
        logic                          last;
    } map_report_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          req_valid   = 1'b0;
    logic                          req_stall;
    logic [fbba_pkg::OP_W-1:0]     op          = fbba_pkg::OP_MARK_USED;
    logic [fbba_pkg::BLK_W-1:0]    block_index = '0;
    logic [fbba_pkg::CNT_W-1:0]    count       = '0;
    logic                          res_valid;
    logic                          res_stall   = 1'b0;
    logic [fbba_pkg::STATUS_W-1:0] status;
    logic [fbba_pkg::BLK_W-1:0]    block_index_out;
    logic                          block_valid;
    logic                          used;
    logic                          last;

    // Shadow copy of the allocator state
    bit                            usage_bits [fbba_pkg::BLOCK_COUNT];
    logic [fbba_pkg::HINT_W-1:0]   free_hint;
    logic [fbba_pkg::HINT_W-1:0]   scan_stop;
    logic [fbba_pkg::REM_W-1:0]    shortfall;

    request_t            request_queue [$];
    map_report_t         awaited_reports [$];

    bit                  calm = 1'b0;
    int                  send_gap;
    int                  stall_left;
    int                  quiet_cycles;
    int                  mismatches;
    int                  requests_taken;
    int                  reports_checked;
    int                  finds_taken;
    int                  finds_off_end;

    free_block_bitmap_allocator dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .op              (op),
        .block_index     (block_index),
        .count           (count),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .block_index_out (block_index_out),
        .block_valid     (block_valid),
        .used            (used),
        .last            (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one request to the shadow map and queue the reports it produces
    task automatic allocate_and_report(input request_t rq);
        map_report_t rp;
        int unsigned wanted;
        int unsigned blk;
        rp      = '0;
        rp.last = 1'b1;
        if (rq.op != fbba_pkg::OP_FIND)
        begin
            if (int'(rq.idx) >= fbba_pkg::BLOCK_COUNT)
            begin
                rp.status = fbba_pkg::ST_RANGE;
            end
            else if (rq.op == fbba_pkg::OP_MARK_USED)
            begin
                usage_bits[rq.idx] = 1'b1;
                if ({1'b0, rq.idx} == free_hint)
                    free_hint = free_hint + 1'b1;
            end
            else if (rq.op == fbba_pkg::OP_MARK_FREE)
            begin
                usage_bits[rq.idx] = 1'b0;
                if ({1'b0, rq.idx} < free_hint)
                    free_hint = {1'b0, rq.idx};
            end
            else
            begin
                rp.blk    = rq.idx;
                rp.bvalid = 1'b1;
                rp.used   = usage_bits[rq.idx];
            end
            awaited_reports.push_back(rp);
        end
        else
        begin
            finds_taken++;
            wanted = (rq.cnt > fbba_pkg::MAX_REQUEST) ? fbba_pkg::MAX_REQUEST : rq.cnt;
            if (wanted == 0)
            begin
                scan_stop = free_hint;
                shortfall = '0;
                awaited_reports.push_back(rp);
            end
            else
            begin
                shortfall = fbba_pkg::REM_W'(wanted);
                blk       = free_hint;
                // Walk upward from the hint, reporting free blocks
                while (blk < fbba_pkg::BLOCK_COUNT && shortfall != 0)
                begin
                    if (!usage_bits[blk])
                    begin
                        shortfall = shortfall - 1'b1;
                        rp.status = fbba_pkg::ST_OK;
                        rp.blk    = fbba_pkg::BLK_W'(blk);
                        rp.bvalid = 1'b1;
                        rp.used   = 1'b0;
                        rp.last   = (shortfall == 0);
                        awaited_reports.push_back(rp);
                    end
                    blk++;
                end
                if (shortfall == 0)
                begin
                    scan_stop = fbba_pkg::HINT_W'(blk - 1);
                end
                else
                begin
                    // Map ran out before the count was met
                    finds_off_end++;
                    scan_stop = fbba_pkg::HINT_W'(fbba_pkg::BLOCK_COUNT);
                    rp        = '0;
                    rp.status = fbba_pkg::ST_NOSPACE;
                    rp.last   = 1'b1;
                    awaited_reports.push_back(rp);
                end
            end
        end
    endtask

    task automatic queue_request(input logic [fbba_pkg::OP_W-1:0] o, input int unsigned idx,
                                 input int unsigned cnt);
        request_t rq;
        rq.op  = o;
        rq.idx = fbba_pkg::BLK_W'(idx);
        rq.cnt = fbba_pkg::CNT_W'(cnt);
        request_queue.push_back(rq);
    endtask

    // Random mix; a crowded map steers block indices toward the top of the device
    task automatic queue_random_requests(input int n, input bit crowded);
        request_t    rq;
        int unsigned pick;
        repeat (n)
        begin
            pick  = $urandom_range(0, 99);
            rq.op = (pick < 30) ? fbba_pkg::OP_MARK_USED :
                    (pick < 55) ? fbba_pkg::OP_MARK_FREE :
                    (pick < 78) ? fbba_pkg::OP_QUERY : fbba_pkg::OP_FIND;
            if ($urandom_range(0, 3) == 0)
                rq.idx = fbba_pkg::BLK_W'($urandom);
            else if (crowded)
                rq.idx = fbba_pkg::BLK_W'($urandom_range(fbba_pkg::BLOCK_COUNT - 600,
                                                         fbba_pkg::BLOCK_COUNT - 1));
            else
                rq.idx = fbba_pkg::BLK_W'($urandom_range(0, 96));
            if ($urandom_range(0, 4) == 0)
                rq.cnt = fbba_pkg::CNT_W'($urandom_range(fbba_pkg::MAX_REQUEST + 1, 31));
            else
                rq.cnt = fbba_pkg::CNT_W'($urandom_range(0, fbba_pkg::MAX_REQUEST));
            request_queue.push_back(rq);
        end
    endtask

    // Hold the sender until every queued request and report has gone through
    task automatic wait_for_drain();
        while (request_queue.size() != 0 || awaited_reports.size() != 0)
            @(negedge clk);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic taken;
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            op          <= fbba_pkg::OP_MARK_USED;
            block_index <= '0;
            count       <= '0;
            send_gap     = 0;
        end
        else
        begin
            taken = req_valid && !req_stall;
            if (taken)
            begin
                allocate_and_report(request_queue.pop_front());
                requests_taken++;
            end
            if (!req_valid || taken)
            begin
                if (send_gap != 0 && !calm)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    send_gap   = $urandom_range(0, 18);
                    req_valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    req_valid   <= 1'b1;
                    op          <= request_queue[0].op;
                    block_index <= request_queue[0].idx;
                    count       <= request_queue[0].cnt;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin : check_reports
        map_report_t got;
        map_report_t want;
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got = {status, block_index_out, block_valid, used, last};
                reports_checked++;
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status=%0d blk=%0d valid=%0b %s%0b %s%0b",
                                 got.status, got.blk, got.bvalid, "used=", got.used,
                                 "last=", got.last);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.status !== want.status || got.blk !== want.blk ||
                        got.bvalid !== want.bvalid || got.used !== want.used ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch at result %0d: expected status=%0d blk=%0d",
                                     reports_checked, want.status, want.blk);
                            $display("    expected valid=%0b used=%0b last=%0b",
                                     want.bvalid, want.used, want.last);
                            $display("    got status=%0d blk=%0d valid=%0b used=%0b last=%0b",
                                     got.status, got.blk, got.bvalid, got.used, got.last);
                        end
                    end
                end
            end
            if (stall_left != 0 && !calm)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d requests, %0d results pending",
                     WATCHDOG_LIMIT, request_queue.size(), awaited_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        // Reserved blocks start out used, hint just above them
        foreach (usage_bits[i])
            usage_bits[i] = (i < fbba_pkg::RES_EFF);
        free_hint       = fbba_pkg::HINT_W'(fbba_pkg::RES_EFF);
        scan_stop       = '0;
        shortfall       = '0;
        quiet_cycles    = 0;
        mismatches      = 0;
        requests_taken  = 0;
        reports_checked = 0;
        finds_taken     = 0;
        finds_off_end   = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reserved area, field extremes, saturation, hint behavior
        queue_request(fbba_pkg::OP_QUERY,     0,                          0);
        queue_request(fbba_pkg::OP_QUERY,     fbba_pkg::RES_EFF - 1,      31);
        queue_request(fbba_pkg::OP_QUERY,     fbba_pkg::RES_EFF,          0);
        queue_request(fbba_pkg::OP_QUERY,     fbba_pkg::BLOCK_COUNT - 1,  0);
        queue_request(fbba_pkg::OP_FIND,      0,                          0);
        queue_request(fbba_pkg::OP_FIND,      0,                          1);
        queue_request(fbba_pkg::OP_FIND,      65535,                      fbba_pkg::MAX_REQUEST);
        queue_request(fbba_pkg::OP_FIND,      0,                          31);
        queue_request(fbba_pkg::OP_FIND,      0,                      fbba_pkg::MAX_REQUEST + 1);
        queue_request(fbba_pkg::OP_MARK_USED, fbba_pkg::RES_EFF,          0);
        queue_request(fbba_pkg::OP_MARK_USED, fbba_pkg::RES_EFF + 2,      0);
        queue_request(fbba_pkg::OP_FIND,      0,                          3);
        queue_request(fbba_pkg::OP_MARK_FREE, 3,                          0);
        queue_request(fbba_pkg::OP_FIND,      0,                          2);
        queue_request(fbba_pkg::OP_MARK_USED, 3,                          0);
        queue_request(fbba_pkg::OP_FIND,      0,                          1);
        queue_request(fbba_pkg::OP_MARK_USED, fbba_pkg::BLOCK_COUNT - 1,  0);
        queue_request(fbba_pkg::OP_QUERY,     fbba_pkg::BLOCK_COUNT - 1,  0);
        queue_request(fbba_pkg::OP_MARK_FREE, fbba_pkg::BLOCK_COUNT - 1,  0);
        queue_request(fbba_pkg::OP_MARK_USED, 16'hAAAA,                   5'h15);
        queue_request(fbba_pkg::OP_MARK_USED, 16'h5555,                   5'h0A);
        queue_request(fbba_pkg::OP_QUERY,     16'hAAAA,                   0);
        queue_request(fbba_pkg::OP_QUERY,     16'h5555,                   0);
        queue_request(fbba_pkg::OP_MARK_FREE, 0,                          0);
        queue_request(fbba_pkg::OP_FIND,      0,                          1);

        // Random traffic on a mostly free map
        queue_random_requests(60, 1'b0);

        // Sender holds off until the block has answered everything
        wait_for_drain();

        // Finds, frees and a query near the top of the device
        queue_request(fbba_pkg::OP_FIND,      0,                          1);
        queue_request(fbba_pkg::OP_FIND,      0,                          0);
        queue_request(fbba_pkg::OP_MARK_FREE, fbba_pkg::BLOCK_COUNT - 6,  0);
        queue_request(fbba_pkg::OP_MARK_FREE, fbba_pkg::BLOCK_COUNT - 1,  0);
        queue_request(fbba_pkg::OP_FIND,      0,                          4);
        queue_request(fbba_pkg::OP_QUERY,     fbba_pkg::BLOCK_COUNT - 6,  0);

        // Random traffic on a crowded map
        queue_random_requests(50, 1'b1);
        wait_for_drain();

        // Closing stretch without idling on either side
        calm = 1'b1;
        queue_random_requests(15, 1'b1);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results; %0d finds, %0d ran past the map end",
                 requests_taken, reports_checked, finds_taken, finds_off_end);
        $display("directed, sparse and top-of-map random traffic; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
